/* sv/kcd_pkg.sv */
package kcd_pkg;

   // Fixed field widths of the stream payloads.
   localparam int VTX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int CORE_W = 10;
   localparam logic [CORE_W-1:0] CORE_MAX = '1;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int MAX_ARCS_DEF     = 8192;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Commands from the controller to the datapath. The controller state
   // is the command it issues.
   localparam int CMD_W = 5;
   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_IDLE    = 5'd0;
   localparam cmd_type CMD_A_BEGIN = 5'd1;
   localparam cmd_type CMD_A_CHECK = 5'd2;
   localparam cmd_type CMD_A_FILL  = 5'd3;
   localparam cmd_type CMD_A_STORE = 5'd4;
   localparam cmd_type CMD_C_BEGIN = 5'd5;
   localparam cmd_type CMD_C_FILL  = 5'd6;
   localparam cmd_type CMD_I_START = 5'd7;
   localparam cmd_type CMD_I_RD    = 5'd8;
   localparam cmd_type CMD_I_WR    = 5'd9;
   localparam cmd_type CMD_S_START = 5'd10;
   localparam cmd_type CMD_S_RD    = 5'd11;
   localparam cmd_type CMD_S_RD2   = 5'd12;
   localparam cmd_type CMD_S_RD3   = 5'd13;
   localparam cmd_type CMD_H_CLR   = 5'd14;
   localparam cmd_type CMD_H_NB    = 5'd15;
   localparam cmd_type CMD_H_W     = 5'd16;
   localparam cmd_type CMD_H_B     = 5'd17;
   localparam cmd_type CMD_H_INC   = 5'd18;
   localparam cmd_type CMD_P_RD    = 5'd19;
   localparam cmd_type CMD_P_ACC   = 5'd20;
   localparam cmd_type CMD_U_WR    = 5'd21;
   localparam cmd_type CMD_D_NB    = 5'd22;
   localparam cmd_type CMD_D_W     = 5'd23;
   localparam cmd_type CMD_D_CHK   = 5'd24;
   localparam cmd_type CMD_Q_RD    = 5'd25;
   localparam cmd_type CMD_Q_OUT   = 5'd26;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic in_query;
      logic done;
      logic arc_ok;
      logic item_last;
      logic item_query;
      logic fill_more;
      logic cfill_more;
      logic u_in;
      logic skip;
      logic clr_last;
      logic i_in;
      logic found;
      logic d_one;
      logic dropped;
      logic changed;
      logic rsp_free;
   } status_type;

endpackage

/* sv/kcore_hindex_decomposer.sv */
// The decomposer loads an undirected graph one arc per request beat, arcs
// grouped by nondecreasing source vertex and each edge given in both
// directions, then finds the core number of every vertex by h-index
// refinement: every bound starts at the vertex degree, and sweeps over all
// vertices lower a bound to the largest d with at least d neighbors whose
// bound is d or more, until a sweep changes nothing. A beat with tlast
// set, or the first query beat, starts the computation; a later arc beat
// opens a new graph and latches csr_wr_data's last written vertex count
// again. Arcs that are out of range, out of order or beyond capacity are
// dropped and raise the load_error flag of every response. Each query
// beat gives one response beat. A stored arc beat is checked, fills the
// offset of each source vertex advanced past the previous source, and is
// written to the neighbor memory; a dropped arc beat ends after the check.
// A query on a computed graph reads the bound memory, then registers its
// response beat, waiting while an earlier response is still not taken. The
// computation is driven by one controller working the offset, neighbor,
// bound, support and histogram memories, each with one read and one write
// port: a setup pass writes each vertex degree as its bound, then each
// sweep reads every vertex; a vertex that is refined clears and builds its
// histogram, scans it for the new bound and, when the bound drops, updates
// the support of its neighbors. No clearing pass is needed after reset.
module kcore_hindex_decomposer
   import kcd_pkg::*;
   #(
      parameter int MAX_VERTICES = MAX_VERTICES_DEF,
      parameter int MAX_ARCS     = MAX_ARCS_DEF
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      // Vertex count register; written whenever csr_wr_en is high.
      input  logic                  csr_wr_en,
      input  logic [CNT_W-1:0]      csr_wr_data,
      input  logic                  req_tvalid,
      output logic                  req_tready,
      // arc_source [9:0], arc_target [19:10], query_vertex [29:20], zero fill
      input  logic [REQ_DATA_W-1:0] req_tdata,
      // operation: 0 loads an arc, 1 queries a vertex
      input  logic                  req_tuser,
      // last_arc
      input  logic                  req_tlast,
      output logic                  rsp_tvalid,
      input  logic                  rsp_tready,
      // result_vertex [9:0], core_number [19:10], load_error [20], zero fill
      output logic [RSP_DATA_W-1:0] rsp_tdata
   );

   cmd_type    cmd;
   status_type status;

   // The controller sequences every load, sweep and query step.
   kcd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   // The datapath holds the graph memories, loop counters and the
   // response register, which lets a finished response wait for the
   // consumer while the next request is taken.
   kcd_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_ARCS     (MAX_ARCS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* sv/kcd_ram.sv */
module kcd_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 16
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/kcd_controller.sv */
module kcd_controller
   import kcd_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      input  logic       req_tvalid,
      input  status_type status,
      output cmd_type    cmd,
      output logic       req_tready
   );

   cmd_type state_ff;
   cmd_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CMD_IDLE: begin
            if (req_tvalid) begin
               if (status.in_query) begin
                  state_in = status.done ? CMD_Q_RD : CMD_C_BEGIN;
               end else begin
                  state_in = CMD_A_BEGIN;
               end
            end
         end
         CMD_A_BEGIN: state_in = CMD_A_CHECK;
         CMD_A_CHECK: begin
            if (status.arc_ok) begin
               state_in = CMD_A_FILL;
            end else begin
               state_in = status.item_last ? CMD_C_BEGIN : CMD_IDLE;
            end
         end
         CMD_A_FILL:  state_in = status.fill_more ? CMD_A_FILL : CMD_A_STORE;
         CMD_A_STORE: state_in = status.item_last ? CMD_C_BEGIN : CMD_IDLE;
         CMD_C_BEGIN: state_in = CMD_C_FILL;
         CMD_C_FILL:  state_in = status.cfill_more ? CMD_C_FILL : CMD_I_START;
         CMD_I_START: state_in = CMD_I_RD;
         CMD_I_RD:    state_in = status.u_in ? CMD_I_WR : CMD_S_START;
         CMD_I_WR:    state_in = CMD_I_RD;
         CMD_S_START: state_in = CMD_S_RD;
         CMD_S_RD: begin
            if (status.u_in) begin
               state_in = CMD_S_RD2;
            end else if (status.changed) begin
               state_in = CMD_S_START;
            end else begin
               state_in = status.item_query ? CMD_Q_RD : CMD_IDLE;
            end
         end
         CMD_S_RD2:   state_in = CMD_S_RD3;
         CMD_S_RD3:   state_in = status.skip ? CMD_S_RD : CMD_H_CLR;
         CMD_H_CLR:   state_in = status.clr_last ? CMD_H_NB : CMD_H_CLR;
         CMD_H_NB:    state_in = status.i_in ? CMD_H_W : CMD_P_RD;
         CMD_H_W:     state_in = CMD_H_B;
         CMD_H_B:     state_in = CMD_H_INC;
         CMD_H_INC:   state_in = CMD_H_NB;
         CMD_P_RD:    state_in = CMD_P_ACC;
         CMD_P_ACC:   state_in = (status.found || status.d_one) ? CMD_U_WR : CMD_P_RD;
         CMD_U_WR:    state_in = status.dropped ? CMD_D_NB : CMD_S_RD;
         CMD_D_NB:    state_in = status.i_in ? CMD_D_W : CMD_S_RD;
         CMD_D_W:     state_in = CMD_D_CHK;
         CMD_D_CHK:   state_in = CMD_D_NB;
         CMD_Q_RD:    state_in = CMD_Q_OUT;
         CMD_Q_OUT:   state_in = status.rsp_free ? CMD_IDLE : CMD_Q_OUT;
         default:     state_in = CMD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CMD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd        = state_ff;
   assign req_tready = (state_ff == CMD_IDLE);

endmodule

/* sv/kcd_datapath.sv */
module kcd_datapath
   import kcd_pkg::*;
   #(
      parameter int MAX_VERTICES = MAX_VERTICES_DEF,
      parameter int MAX_ARCS     = MAX_ARCS_DEF
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  cmd_type               cmd,
      output status_type            status,
      input  logic                  csr_wr_en,
      input  logic [CNT_W-1:0]      csr_wr_data,
      input  logic                  req_tvalid,
      input  logic [REQ_DATA_W-1:0] req_tdata,
      input  logic                  req_tuser,
      input  logic                  req_tlast,
      output logic                  rsp_tvalid,
      input  logic                  rsp_tready,
      output logic [RSP_DATA_W-1:0] rsp_tdata
   );

   localparam int VA_W  = $clog2(MAX_VERTICES);
   localparam int VN_W  = $clog2(MAX_VERTICES + 1);
   localparam int FV_W  = $clog2(MAX_VERTICES + 2);
   localparam int AA_W  = $clog2(MAX_ARCS);
   localparam int AN_W  = $clog2(MAX_ARCS + 1);
   localparam int CW    = (FV_W > CNT_W) ? FV_W : CNT_W;
   localparam int SAT_W = (AN_W > CORE_W) ? AN_W : CORE_W;

   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [VN_W-1:0]  graph_n_ff, graph_n_in;
   logic             started_ff, started_in;
   logic             done_ff, done_in;
   logic             err_ff, err_in;
   logic [AN_W-1:0]  arcs_ff, arcs_in;
   logic [VTX_W-1:0] prev_ff, prev_in;
   logic             changed_ff, changed_in;

   logic             it_query_ff, it_query_in;
   logic             it_last_ff, it_last_in;
   logic [VTX_W-1:0] it_src_ff, it_src_in;
   logic [VTX_W-1:0] it_tgt_ff, it_tgt_in;
   logic [VTX_W-1:0] it_qv_ff, it_qv_in;

   logic [FV_W-1:0]  v_ff, v_in;
   logic [VN_W-1:0]  u_ff, u_in;
   logic [AN_W-1:0]  lo_ff, lo_in;
   logic [AN_W-1:0]  hi_ff, hi_in;
   logic [AN_W-1:0]  old_ff, old_in;
   logic [AN_W-1:0]  sup_ff, sup_in;
   logic [AN_W-1:0]  i_ff, i_in;
   logic [AN_W-1:0]  d_ff, d_in;
   logic [AN_W-1:0]  acc_ff, acc_in;
   logic [AN_W-1:0]  nb_ff, nb_in;
   logic [AN_W-1:0]  m_ff, m_in;
   logic [VTX_W-1:0] w_ff, w_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]  rsp_vtx_ff, rsp_vtx_in;
   logic [CORE_W-1:0] rsp_core_ff, rsp_core_in;
   logic              rsp_err_ff, rsp_err_in;

   // Memory ports.
   logic            off_we, off_re;
   logic [VN_W-1:0] off_wa, off_ra;
   logic [AN_W-1:0] off_wd, off_rd;
   logic            nbr_we, nbr_re;
   logic [AA_W-1:0] nbr_wa, nbr_ra;
   logic [VTX_W-1:0] nbr_wd, nbr_rd;
   logic            bnd_we, bnd_re;
   logic [VA_W-1:0] bnd_wa, bnd_ra;
   logic [AN_W-1:0] bnd_wd, bnd_rd;
   logic            sup_we, sup_re;
   logic [VA_W-1:0] sup_wa, sup_ra;
   logic [AN_W-1:0] sup_wd, sup_rd;
   logic            hst_we, hst_re;
   logic [AN_W-1:0] hst_wa, hst_ra;
   logic [AN_W-1:0] hst_wd, hst_rd;

   logic [AN_W-1:0] acc_sum;
   logic [VN_W-1:0] n_clip;
   logic            rsp_free;
   logic            arc_ok;

   kcd_ram #(.WIDTH(AN_W), .DEPTH(MAX_VERTICES + 1)) u_offsets (
      .clock(clock), .wr_en(off_we), .wr_addr(off_wa), .wr_data(off_wd),
      .rd_en(off_re), .rd_addr(off_ra), .rd_data(off_rd)
   );
   kcd_ram #(.WIDTH(VTX_W), .DEPTH(MAX_ARCS)) u_neighbors (
      .clock(clock), .wr_en(nbr_we), .wr_addr(nbr_wa), .wr_data(nbr_wd),
      .rd_en(nbr_re), .rd_addr(nbr_ra), .rd_data(nbr_rd)
   );
   kcd_ram #(.WIDTH(AN_W), .DEPTH(MAX_VERTICES)) u_bound (
      .clock(clock), .wr_en(bnd_we), .wr_addr(bnd_wa), .wr_data(bnd_wd),
      .rd_en(bnd_re), .rd_addr(bnd_ra), .rd_data(bnd_rd)
   );
   kcd_ram #(.WIDTH(AN_W), .DEPTH(MAX_VERTICES)) u_support (
      .clock(clock), .wr_en(sup_we), .wr_addr(sup_wa), .wr_data(sup_wd),
      .rd_en(sup_re), .rd_addr(sup_ra), .rd_data(sup_rd)
   );
   kcd_ram #(.WIDTH(AN_W), .DEPTH(MAX_ARCS + 1)) u_histogram (
      .clock(clock), .wr_en(hst_we), .wr_addr(hst_wa), .wr_data(hst_wd),
      .rd_en(hst_re), .rd_addr(hst_ra), .rd_data(hst_rd)
   );

   assign acc_sum  = acc_ff + hst_rd;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign n_clip   = (CW'(vcount_ff) > CW'(MAX_VERTICES)) ? VN_W'(MAX_VERTICES)
                                                          : VN_W'(vcount_ff);
   assign arc_ok   = (CW'(it_src_ff) < CW'(graph_n_ff)) &&
                     (CW'(it_tgt_ff) < CW'(graph_n_ff)) &&
                     (it_src_ff >= prev_ff) && (arcs_ff < AN_W'(MAX_ARCS));

   always_comb begin
      logic             fresh;
      logic [SAT_W-1:0] wide;

      fresh        = 1'b0;
      wide         = SAT_W'(bnd_rd);

      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      graph_n_in   = graph_n_ff;
      started_in   = started_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      arcs_in      = arcs_ff;
      prev_in      = prev_ff;
      changed_in   = changed_ff;
      it_query_in  = it_query_ff;
      it_last_in   = it_last_ff;
      it_src_in    = it_src_ff;
      it_tgt_in    = it_tgt_ff;
      it_qv_in     = it_qv_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      old_in       = old_ff;
      sup_in       = sup_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      nb_in        = nb_ff;
      m_in         = m_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_vtx_in   = rsp_vtx_ff;
      rsp_core_in  = rsp_core_ff;
      rsp_err_in   = rsp_err_ff;

      off_we = 1'b0; off_wa = '0; off_wd = '0; off_re = 1'b0; off_ra = '0;
      nbr_we = 1'b0; nbr_wa = '0; nbr_wd = '0; nbr_re = 1'b0; nbr_ra = '0;
      bnd_we = 1'b0; bnd_wa = '0; bnd_wd = '0; bnd_re = 1'b0; bnd_ra = '0;
      sup_we = 1'b0; sup_wa = '0; sup_wd = '0; sup_re = 1'b0; sup_ra = '0;
      hst_we = 1'b0; hst_wa = '0; hst_wd = '0; hst_re = 1'b0; hst_ra = '0;

      case (cmd)
         CMD_IDLE: begin
            if (req_tvalid) begin
               it_query_in = (req_tuser == OP_QUERY);
               it_last_in  = req_tlast;
               it_src_in   = req_tdata[VTX_W-1:0];
               it_tgt_in   = req_tdata[2*VTX_W-1:VTX_W];
               it_qv_in    = req_tdata[3*VTX_W-1:2*VTX_W];
            end
         end
         CMD_A_BEGIN: begin
            // An arc after a finished computation opens a new graph.
            fresh = !started_ff || done_ff;
            if (done_ff) begin
               arcs_in    = '0;
               prev_in    = '0;
               err_in     = 1'b0;
               changed_in = 1'b0;
               done_in    = 1'b0;
            end
            if (fresh) begin
               graph_n_in = n_clip;
               started_in = 1'b1;
               off_we     = 1'b1;
            end
            v_in = (done_ff ? '0 : FV_W'(prev_ff)) + FV_W'(1);
         end
         CMD_A_CHECK: begin
            if (!arc_ok) begin
               err_in = 1'b1;
            end
         end
         CMD_A_FILL: begin
            if (status.fill_more) begin
               off_we = 1'b1;
               off_wa = VN_W'(v_ff);
               off_wd = arcs_ff;
               v_in   = v_ff + FV_W'(1);
            end
         end
         CMD_A_STORE: begin
            nbr_we  = 1'b1;
            nbr_wa  = AA_W'(arcs_ff);
            nbr_wd  = it_tgt_ff;
            arcs_in = arcs_ff + AN_W'(1);
            prev_in = it_src_ff;
         end
         CMD_C_BEGIN: begin
            if (!started_ff) begin
               graph_n_in = n_clip;
               started_in = 1'b1;
               off_we     = 1'b1;
            end
            v_in = FV_W'(prev_ff) + FV_W'(1);
         end
         CMD_C_FILL: begin
            if (status.cfill_more) begin
               off_we = 1'b1;
               off_wa = VN_W'(v_ff);
               off_wd = arcs_ff;
               v_in   = v_ff + FV_W'(1);
            end
         end
         CMD_I_START: begin
            u_in  = '0;
            lo_in = '0;
         end
         CMD_I_RD: begin
            off_re = 1'b1;
            off_ra = u_ff + VN_W'(1);
         end
         CMD_I_WR: begin
            bnd_we = 1'b1;
            bnd_wa = VA_W'(u_ff);
            bnd_wd = off_rd - lo_ff;
            sup_we = 1'b1;
            sup_wa = VA_W'(u_ff);
            lo_in  = off_rd;
            u_in   = u_ff + VN_W'(1);
         end
         CMD_S_START: begin
            changed_in = 1'b0;
            u_in       = '0;
         end
         CMD_S_RD: begin
            if (status.u_in) begin
               off_re = 1'b1;
               off_ra = u_ff;
               bnd_re = 1'b1;
               bnd_ra = VA_W'(u_ff);
               sup_re = 1'b1;
               sup_ra = VA_W'(u_ff);
            end else if (!changed_ff) begin
               done_in = 1'b1;
            end
         end
         CMD_S_RD2: begin
            lo_in  = off_rd;
            old_in = bnd_rd;
            sup_in = sup_rd;
            off_re = 1'b1;
            off_ra = u_ff + VN_W'(1);
         end
         CMD_S_RD3: begin
            hi_in = off_rd;
            if (status.skip) begin
               u_in = u_ff + VN_W'(1);
            end else begin
               d_in = '0;
            end
         end
         CMD_H_CLR: begin
            hst_we = 1'b1;
            hst_wa = d_ff;
            if (status.clr_last) begin
               i_in = lo_ff;
            end else begin
               d_in = d_ff + AN_W'(1);
            end
         end
         CMD_H_NB: begin
            if (status.i_in) begin
               nbr_re = 1'b1;
               nbr_ra = AA_W'(i_ff);
            end else begin
               acc_in = '0;
               d_in   = old_ff;
            end
         end
         CMD_H_W: begin
            bnd_re = 1'b1;
            bnd_ra = VA_W'(nbr_rd);
         end
         CMD_H_B: begin
            m_in   = (bnd_rd < old_ff) ? bnd_rd : old_ff;
            hst_re = 1'b1;
            hst_ra = (bnd_rd < old_ff) ? bnd_rd : old_ff;
         end
         CMD_H_INC: begin
            hst_we = 1'b1;
            hst_wa = m_ff;
            hst_wd = hst_rd + AN_W'(1);
            i_in   = i_ff + AN_W'(1);
         end
         CMD_P_RD: begin
            hst_re = 1'b1;
            hst_ra = d_ff;
         end
         CMD_P_ACC: begin
            acc_in = acc_sum;
            if (status.found) begin
               nb_in = d_ff;
            end else if (status.d_one) begin
               nb_in = '0;
            end else begin
               d_in = d_ff - AN_W'(1);
            end
         end
         CMD_U_WR: begin
            sup_we = 1'b1;
            sup_wa = VA_W'(u_ff);
            sup_wd = acc_ff;
            bnd_we = 1'b1;
            bnd_wa = VA_W'(u_ff);
            bnd_wd = nb_ff;
            if (status.dropped) begin
               changed_in = 1'b1;
               i_in       = lo_ff;
            end else begin
               u_in = u_ff + VN_W'(1);
            end
         end
         CMD_D_NB: begin
            if (status.i_in) begin
               nbr_re = 1'b1;
               nbr_ra = AA_W'(i_ff);
            end else begin
               u_in = u_ff + VN_W'(1);
            end
         end
         CMD_D_W: begin
            w_in   = nbr_rd;
            bnd_re = 1'b1;
            bnd_ra = VA_W'(nbr_rd);
            sup_re = 1'b1;
            sup_ra = VA_W'(nbr_rd);
         end
         CMD_D_CHK: begin
            // The neighbor loses one unit of support when this drop crossed
            // its bound and its support was still counted in full.
            if (bnd_rd > nb_ff && bnd_rd <= old_ff && sup_rd >= bnd_rd) begin
               sup_we = 1'b1;
               sup_wa = VA_W'(w_ff);
               sup_wd = sup_rd - AN_W'(1);
            end
            i_in = i_ff + AN_W'(1);
         end
         CMD_Q_RD: begin
            bnd_re = 1'b1;
            bnd_ra = VA_W'(it_qv_ff);
         end
         CMD_Q_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_vtx_in   = it_qv_ff;
               rsp_err_in   = err_ff;
               if (CW'(it_qv_ff) < CW'(graph_n_ff)) begin
                  rsp_core_in = (wide > SAT_W'(CORE_MAX)) ? CORE_MAX : CORE_W'(wide);
               end else begin
                  rsp_core_in = '0;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         graph_n_ff   <= '0;
         started_ff   <= 1'b0;
         done_ff      <= 1'b0;
         err_ff       <= 1'b0;
         arcs_ff      <= '0;
         prev_ff      <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         graph_n_ff   <= graph_n_in;
         started_ff   <= started_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
         arcs_ff      <= arcs_in;
         prev_ff      <= prev_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_query_ff <= it_query_in;
      it_last_ff  <= it_last_in;
      it_src_ff   <= it_src_in;
      it_tgt_ff   <= it_tgt_in;
      it_qv_ff    <= it_qv_in;
      v_ff        <= v_in;
      u_ff        <= u_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      old_ff      <= old_in;
      sup_ff      <= sup_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      nb_ff       <= nb_in;
      m_ff        <= m_in;
      w_ff        <= w_in;
      rsp_vtx_ff  <= rsp_vtx_in;
      rsp_core_ff <= rsp_core_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign status.in_query   = (req_tuser == OP_QUERY);
   assign status.done       = done_ff;
   assign status.arc_ok     = arc_ok;
   assign status.item_last  = it_last_ff;
   assign status.item_query = it_query_ff;
   assign status.fill_more  = CW'(v_ff) <= CW'(it_src_ff);
   assign status.cfill_more = CW'(v_ff) <= CW'(graph_n_ff);
   assign status.u_in       = u_ff < graph_n_ff;
   assign status.skip       = sup_ff >= old_ff;
   assign status.clr_last   = d_ff == old_ff;
   assign status.i_in       = i_ff < hi_ff;
   assign status.found      = acc_sum >= d_ff;
   assign status.d_one      = d_ff == AN_W'(1);
   assign status.dropped    = nb_ff < old_ff;
   assign status.changed    = changed_ff;
   assign status.rsp_free   = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VTX_W - CORE_W - 1)'(0),
                        rsp_err_ff, rsp_core_ff, rsp_vtx_ff};

endmodule

/* sv/kcd_checker.sv */
module kcd_checker
   (
      input logic clock,
      input logic reset,
      input logic req_tvalid,
      input logic req_tready,
      input logic rsp_tvalid,
      input logic rsp_tready
   );

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped before it was taken");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // An accepted request leaves the block not ready in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in work");

endmodule

bind kcore_hindex_decomposer kcd_checker u_kcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
